>>> sv/spol_pkg.sv
// ----------------------------------------------------------------------------
// spol_pkg: shared types and constants for segment_to_polar
// Widths, stage payload, case classes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package spol_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int SQ_W       = 50;
    localparam int ROT_W      = 36;
    localparam int Z_W        = 26;
    localparam int ANGLE_W    = 17;
    localparam int DIST_W     = 25;
    localparam int SQRT_STEPS = 25;
    localparam int TABLE_LEN  = 24;
    localparam int FRAC_SHIFT = 8;

    localparam logic signed [Z_W-1:0]     Z_PI         = 26'sd8388608;
    localparam logic signed [Z_W-1:0]     Z_ROUND      = 26'sd128;
    localparam logic signed [ANGLE_W-1:0] ANG_PI       = 17'sd32768;
    localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI  = 17'sd16384;
    localparam logic signed [ANGLE_W-1:0] ANG_ZERO     = 17'sd0;
    localparam logic [DIST_W-1:0]         DIST_MAX     = 25'd23726566;

    typedef enum logic [1:0] {
        CLS_GENERAL,
        CLS_ZERO,
        CLS_Y_AXIS,
        CLS_X_AXIS
    } spol_cls_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [ROT_W-1:0]   cx;
        logic signed [ROT_W-1:0]   cy;
        logic signed [Z_W-1:0]     cz;
        logic [SQ_W-1:0]           root;
        logic [SQ_W-1:0]           rem;
        spol_cls_t                 cls;
        logic                      neg;
    } spol_stage_t;

    // atan(2^-i) in units of pi / 2^23
    function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            0:       r = 26'sd2097152;
            1:       r = 26'sd1238021;
            2:       r = 26'sd654136;
            3:       r = 26'sd332050;
            4:       r = 26'sd166669;
            5:       r = 26'sd83416;
            6:       r = 26'sd41718;
            7:       r = 26'sd20860;
            8:       r = 26'sd10430;
            9:       r = 26'sd5215;
            10:      r = 26'sd2608;
            11:      r = 26'sd1304;
            12:      r = 26'sd652;
            13:      r = 26'sd326;
            14:      r = 26'sd163;
            15:      r = 26'sd81;
            16:      r = 26'sd41;
            17:      r = 26'sd20;
            18:      r = 26'sd10;
            19:      r = 26'sd5;
            20:      r = 26'sd3;
            21:      r = 26'sd1;
            22:      r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/segment_to_polar.sv
// ----------------------------------------------------------------------------
// segment_to_polar: polar form of a line segment's difference vector
// Pipelined CORDIC vectoring for the angle and a bit-per-stage square root.
//
//   Channel  Signals                               Dir  Payload
//   input    in_valid / in_ready                   in   start_x start_y end_x end_y
//   output   out_valid / out_ready                 out  origin_x origin_y angle distance
//
// One item per cycle while the output is not stalled; three front-end stages,
// one stage per root bit (25 bits), one output register. The root sets the depth.
// Reset clears the valid bits only; the pipeline is empty after reset.
// A stall on the output freezes every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module segment_to_polar #(
    parameter int ITERATIONS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [spol_pkg::COORD_W-1:0]  start_x,
    input  logic signed [spol_pkg::COORD_W-1:0]  start_y,
    input  logic signed [spol_pkg::COORD_W-1:0]  end_x,
    input  logic signed [spol_pkg::COORD_W-1:0]  end_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [spol_pkg::COORD_W-1:0]  origin_x,
    output logic signed [spol_pkg::COORD_W-1:0]  origin_y,
    output logic signed [spol_pkg::ANGLE_W-1:0]  angle,
    output logic [spol_pkg::DIST_W-1:0]          distance
);

    localparam int ROT_STEPS = (ITERATIONS > spol_pkg::TABLE_LEN) ?
                               spol_pkg::TABLE_LEN : ITERATIONS;
    localparam int NSTEP     = spol_pkg::SQRT_STEPS;

    logic                  adv;
    logic                  st_valid [0:NSTEP];
    spol_pkg::spol_stage_t st_stage [0:NSTEP];

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    spol_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (st_valid[0]),
        .out_stage (st_stage[0])
    );

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        spol_step #(
            .STEP   (k),
            .ROTATE (k < ROT_STEPS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (st_valid[k]),
            .in_stage  (st_stage[k]),
            .out_valid (st_valid[k+1]),
            .out_stage (st_stage[k+1])
        );
    end

    spol_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (st_valid[NSTEP]),
        .in_stage  (st_stage[NSTEP]),
        .out_valid (out_valid),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .angle     (angle),
        .distance  (distance)
    );

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance <= spol_pkg::DIST_MAX)
        else $error("distance above maximum segment length");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle > -spol_pkg::ANG_PI) && (angle <= spol_pkg::ANG_PI))
        else $error("angle outside (-pi, pi]");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && distance == '0 |-> angle == spol_pkg::ANG_ZERO)
        else $error("zero-length item with nonzero angle");

endmodule

>>> sv/spol_prep.sv
// ----------------------------------------------------------------------------
// spol_prep: front end of the segment_to_polar pipeline
// Three stages: difference vector, squares and CORDIC setup, sum of squares.
// ----------------------------------------------------------------------------
module spol_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic signed [spol_pkg::COORD_W-1:0]    start_x,
    input  logic signed [spol_pkg::COORD_W-1:0]    start_y,
    input  logic signed [spol_pkg::COORD_W-1:0]    end_x,
    input  logic signed [spol_pkg::COORD_W-1:0]    end_y,
    output logic                                   out_valid,
    output spol_pkg::spol_stage_t                  out_stage
);

    logic signed [spol_pkg::COORD_W-1:0] a_sx_reg, a_sy_reg;
    logic signed [spol_pkg::DIFF_W-1:0]  a_dx_reg, a_dy_reg;
    logic signed [spol_pkg::DIFF_W-1:0]  a_dx_next, a_dy_next;
    logic                                a_valid_reg;

    logic signed [spol_pkg::SQ_W-1:0]    b_sqx_reg, b_sqy_reg;
    logic signed [spol_pkg::SQ_W-1:0]    b_sqx_next, b_sqy_next;
    spol_pkg::spol_stage_t               b_stage_reg, b_stage_next;
    logic                                b_valid_reg;

    spol_pkg::spol_stage_t               c_stage_reg, c_stage_next;
    logic                                c_valid_reg;

    logic signed [spol_pkg::ROT_W-1:0]   dx_sh, dy_sh;
    logic                                dx_neg;

    assign a_dx_next = spol_pkg::DIFF_W'(end_x) - spol_pkg::DIFF_W'(start_x);
    assign a_dy_next = spol_pkg::DIFF_W'(end_y) - spol_pkg::DIFF_W'(start_y);

    assign b_sqx_next = a_dx_reg * a_dx_reg;
    assign b_sqy_next = a_dy_reg * a_dy_reg;
    assign dx_sh      = spol_pkg::ROT_W'(a_dx_reg) <<< spol_pkg::FRAC_SHIFT;
    assign dy_sh      = spol_pkg::ROT_W'(a_dy_reg) <<< spol_pkg::FRAC_SHIFT;
    assign dx_neg     = a_dx_reg < 0;

    always_comb
    begin
        b_stage_next      = '0;
        b_stage_next.sx   = a_sx_reg;
        b_stage_next.sy   = a_sy_reg;
        // rotate left half-plane vectors by pi
        b_stage_next.cx   = dx_neg ? -dx_sh : dx_sh;
        b_stage_next.cy   = dx_neg ? -dy_sh : dy_sh;
        if (!dx_neg)
        begin
            b_stage_next.cz = '0;
        end
        else if (a_dy_reg > 0)
        begin
            b_stage_next.cz = spol_pkg::Z_PI;
        end
        else
        begin
            b_stage_next.cz = -spol_pkg::Z_PI;
        end
        if (a_dx_reg == 0 && a_dy_reg == 0)
        begin
            b_stage_next.cls = spol_pkg::CLS_ZERO;
            b_stage_next.neg = 1'b0;
        end
        else if (a_dx_reg == 0)
        begin
            b_stage_next.cls = spol_pkg::CLS_Y_AXIS;
            b_stage_next.neg = a_dy_reg < 0;
        end
        else if (a_dy_reg == 0)
        begin
            b_stage_next.cls = spol_pkg::CLS_X_AXIS;
            b_stage_next.neg = dx_neg;
        end
        else
        begin
            b_stage_next.cls = spol_pkg::CLS_GENERAL;
            b_stage_next.neg = 1'b0;
        end
    end

    always_comb
    begin
        c_stage_next      = b_stage_reg;
        c_stage_next.rem  = unsigned'(b_sqx_reg) + unsigned'(b_sqy_reg);
        c_stage_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sx_reg    <= start_x;
            a_sy_reg    <= start_y;
            a_dx_reg    <= a_dx_next;
            a_dy_reg    <= a_dy_next;
            b_sqx_reg   <= b_sqx_next;
            b_sqy_reg   <= b_sqy_next;
            b_stage_reg <= b_stage_next;
            c_stage_reg <= c_stage_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_stage = c_stage_reg;

endmodule

>>> sv/spol_step.sv
// ----------------------------------------------------------------------------
// spol_step: one pipeline stage of square root and CORDIC vectoring
// Resolves one root bit and, when enabled, performs one micro-rotation.
// ----------------------------------------------------------------------------
module spol_step #(
    parameter int STEP   = 0,
    parameter bit ROTATE = 1'b1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  spol_pkg::spol_stage_t in_stage,
    output logic                  out_valid,
    output spol_pkg::spol_stage_t out_stage
);

    localparam int BIT_POS = 2 * (spol_pkg::SQRT_STEPS - 1 - STEP);
    localparam logic [spol_pkg::SQ_W-1:0] SQ_BIT =
        {{(spol_pkg::SQ_W-1){1'b0}}, 1'b1} << BIT_POS;
    localparam logic signed [spol_pkg::Z_W-1:0] ATAN =
        spol_pkg::atan_lut(STEP);

    spol_pkg::spol_stage_t             stage_reg, stage_next;
    logic                              valid_reg;
    logic [spol_pkg::SQ_W-1:0]         trial;
    logic signed [spol_pkg::ROT_W-1:0] xs, ys;

    assign trial = in_stage.root + SQ_BIT;
    assign xs    = in_stage.cx >>> STEP;
    assign ys    = in_stage.cy >>> STEP;

    always_comb
    begin
        stage_next = in_stage;
        if (in_stage.rem >= trial)
        begin
            stage_next.rem  = in_stage.rem - trial;
            stage_next.root = (in_stage.root >> 1) + SQ_BIT;
        end
        else
        begin
            stage_next.root = in_stage.root >> 1;
        end
        if (ROTATE)
        begin
            if (in_stage.cy > 0)
            begin
                stage_next.cx = in_stage.cx + ys;
                stage_next.cy = in_stage.cy - xs;
                stage_next.cz = in_stage.cz + ATAN;
            end
            else
            begin
                stage_next.cx = in_stage.cx - ys;
                stage_next.cy = in_stage.cy + xs;
                stage_next.cz = in_stage.cz - ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

>>> sv/spol_finish.sv
// ----------------------------------------------------------------------------
// spol_finish: output stage of segment_to_polar
// Rounds root and angle, wraps the angle, selects axis cases, holds result.
// ----------------------------------------------------------------------------
module spol_finish (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  spol_pkg::spol_stage_t                in_stage,
    output logic                                 out_valid,
    output logic signed [spol_pkg::COORD_W-1:0]  origin_x,
    output logic signed [spol_pkg::COORD_W-1:0]  origin_y,
    output logic signed [spol_pkg::ANGLE_W-1:0]  angle,
    output logic [spol_pkg::DIST_W-1:0]          distance
);

    localparam int WRAP_W = spol_pkg::ANGLE_W + 2;

    logic                                valid_reg;
    logic signed [spol_pkg::COORD_W-1:0] ox_reg, oy_reg;
    logic signed [spol_pkg::ANGLE_W-1:0] ang_reg, ang_next;
    logic [spol_pkg::DIST_W-1:0]         dist_reg, dist_next;
    logic signed [spol_pkg::Z_W-1:0]     z_rnd;
    logic signed [WRAP_W-1:0]            a_raw, a_wrap;
    logic [spol_pkg::SQ_W-1:0]           root_rnd;

    assign z_rnd = (in_stage.cz + spol_pkg::Z_ROUND) >>> spol_pkg::FRAC_SHIFT;
    assign a_raw = WRAP_W'(z_rnd);

    always_comb
    begin
        if (a_raw > WRAP_W'(spol_pkg::ANG_PI))
        begin
            a_wrap = a_raw - (WRAP_W'(spol_pkg::ANG_PI) <<< 1);
        end
        else if (a_raw <= -WRAP_W'(spol_pkg::ANG_PI))
        begin
            a_wrap = a_raw + (WRAP_W'(spol_pkg::ANG_PI) <<< 1);
        end
        else
        begin
            a_wrap = a_raw;
        end
    end

    always_comb
    begin
        case (in_stage.cls)
            spol_pkg::CLS_ZERO:
            begin
                ang_next = spol_pkg::ANG_ZERO;
            end
            spol_pkg::CLS_Y_AXIS:
            begin
                ang_next = in_stage.neg ? -spol_pkg::ANG_HALF_PI : spol_pkg::ANG_HALF_PI;
            end
            spol_pkg::CLS_X_AXIS:
            begin
                ang_next = in_stage.neg ? spol_pkg::ANG_PI : spol_pkg::ANG_ZERO;
            end
            default:
            begin
                ang_next = spol_pkg::ANGLE_W'(a_wrap);
            end
        endcase
    end

    // round half up on the remainder
    assign root_rnd  = in_stage.root
                     + spol_pkg::SQ_W'(in_stage.rem > in_stage.root);
    assign dist_next = root_rnd[spol_pkg::DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg   <= in_stage.sx;
            oy_reg   <= in_stage.sy;
            ang_reg  <= ang_next;
            dist_reg <= dist_next;
        end
    end

    assign out_valid = valid_reg;
    assign origin_x  = ox_reg;
    assign origin_y  = oy_reg;
    assign angle     = ang_reg;
    assign distance  = dist_reg;

endmodule
